/* rtl/core/u8u16_pkg.sv */
`timescale 1ns / 1ps

package u8u16_pkg;

  // byte class bounds for a lead byte
  localparam logic [7:0] LeadTwoMin   = 8'hc0;
  localparam logic [7:0] LeadThreeMin = 8'he0;
  localparam logic [7:0] LeadFourMin  = 8'hf0;
  localparam logic [7:0] LeadBadMin   = 8'hf8;

  // code point ranges
  localparam logic [20:0] BmpLowMax     = 21'h00d7ff;
  localparam logic [20:0] BmpHighMin    = 21'h00e000;
  localparam logic [20:0] BmpHighMax    = 21'h00ffff;
  localparam logic [20:0] SupplMin      = 21'h010000;
  localparam logic [20:0] SupplMax      = 21'h10ffff;
  localparam logic [15:0] HighSurrBase  = 16'hd800;
  localparam logic [15:0] LowSurrBase   = 16'hdc00;

  // output queue depth
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // one result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        run_last;
    logic        string_end;
  } result_t;

  // decoder outcome for one accepted byte
  typedef struct packed {
    logic [1:0]  owed_next;
    logic [20:0] point_next;
    logic [1:0]  count;
    result_t     res0;
    result_t     res1;
  } dec_out_t;

endpackage

/* rtl/core/u8u16_decode.sv */
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic [1:0]           owed,
  input  logic [20:0]          point,
  input  logic [7:0]           text_byte,
  input  logic                 string_last,
  output u8u16_pkg::dec_out_t  dec
);

  logic [20:0] cp;
  logic        emit_en;
  logic        is_single;
  logic        is_pair;
  logic [20:0] offs;
  logic [1:0]  owed_dec;
  logic [20:0] point_shift;

  always_comb begin
    // gather bits and find the completed code point
    owed_dec    = owed - 2'd1;
    point_shift = {point[14:0], text_byte[5:0]};
    dec.owed_next  = owed;
    dec.point_next = point;
    cp      = point_shift;
    emit_en = 1'b0;
    if (owed == 2'd0) begin
      cp = {13'd0, text_byte};
      if (text_byte < u8u16_pkg::LeadTwoMin || text_byte >= u8u16_pkg::LeadBadMin) begin
        emit_en = 1'b1;
      end else if (text_byte < u8u16_pkg::LeadThreeMin) begin
        dec.owed_next  = 2'd1;
        dec.point_next = {16'd0, text_byte[4:0]};
      end else if (text_byte < u8u16_pkg::LeadFourMin) begin
        dec.owed_next  = 2'd2;
        dec.point_next = {17'd0, text_byte[3:0]};
      end else begin
        dec.owed_next  = 2'd3;
        dec.point_next = {18'd0, text_byte[2:0]};
      end
    end else begin
      dec.owed_next  = owed_dec;
      dec.point_next = point_shift;
      if (owed_dec == 2'd0) begin
        emit_en        = 1'b1;
        dec.point_next = '0;
      end
    end
    if (string_last) begin
      dec.owed_next  = '0;
      dec.point_next = '0;
    end

    // utf-16 form of the code point
    is_single = emit_en && (cp <= u8u16_pkg::BmpLowMax ||
                (cp >= u8u16_pkg::BmpHighMin && cp <= u8u16_pkg::BmpHighMax));
    is_pair   = emit_en && cp >= u8u16_pkg::SupplMin && cp <= u8u16_pkg::SupplMax;
    offs      = cp - u8u16_pkg::SupplMin;
    dec.res0  = '0;
    dec.res1  = '0;
    dec.count = 2'd0;
    if (is_single) begin
      dec.res0.code_unit  = cp[15:0];
      dec.res0.unit_valid = 1'b1;
      dec.count           = 2'd1;
    end else if (is_pair) begin
      dec.res0.code_unit  = u8u16_pkg::HighSurrBase | {6'd0, offs[19:10]};
      dec.res0.unit_valid = 1'b1;
      dec.res1.code_unit  = u8u16_pkg::LowSurrBase | {6'd0, offs[9:0]};
      dec.res1.unit_valid = 1'b1;
      dec.count           = 2'd2;
    end
    // bare end marker when a string ends with no unit
    if (string_last && dec.count == 2'd0) begin
      dec.count = 2'd1;
    end
    // mark the final result of this byte
    if (dec.count == 2'd2) begin
      dec.res1.run_last   = 1'b1;
      dec.res1.string_end = string_last;
    end else begin
      dec.res0.run_last   = 1'b1;
      dec.res0.string_end = string_last;
    end
  end

endmodule

/* rtl/core/utf8_to_utf16_converter.sv */
`timescale 1ns / 1ps

// UTF-8 to UTF-16 transcoder. Takes one UTF-8 byte per cycle on the slave
// side while not stalled (tlast marks a string's last byte) and gives UTF-16
// code units on the master side, a surrogate pair as two requests with the
// high unit first. A byte passes an input register and then one decode step
// into a four-entry output queue. The byte stream sustains one byte per
// cycle; only the output port rate limits it, since a byte that yields a
// surrogate pair needs two output requests and the input stalls while the
// queue has fewer than two free entries. A string's last byte that yields
// no unit gives a bare end marker (tuser bit 0 low); bytes that complete
// nothing give no request.
module utf8_to_utf16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // string_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser,   // [0] unit_valid, [1] run_last
  output logic        m_axis_tlast    // string_end
);

  localparam int Aw = u8u16_pkg::QueueAw;

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic [1:0]             owed;
  logic [20:0]            point;
  u8u16_pkg::dec_out_t    dec;
  u8u16_pkg::result_t     queue [u8u16_pkg::QueueDepth];
  logic [Aw-1:0]          wr_ptr;
  logic [Aw-1:0]          rd_ptr;
  logic [Aw:0]            count;
  logic [Aw:0]            count_next;
  logic                   consume;
  logic                   pop;
  logic [Aw:0]            push_n;
  u8u16_pkg::result_t     head;

  u8u16_decode u_decode (
    .owed        (owed),
    .point       (point),
    .text_byte   (in_byte),
    .string_last (in_last),
    .dec         (dec)
  );

  // handshake control
  assign consume       = in_valid && (count <= (Aw+1)'(u8u16_pkg::QueueDepth - 2));
  assign s_axis_tready = !in_valid || consume;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = consume ? {{(Aw-1){1'b0}}, dec.count} : '0;
  assign count_next    = count + push_n - {{Aw{1'b0}}, pop};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      owed  <= '0;
      point <= '0;
    end else if (consume) begin
      owed  <= dec.owed_next;
      point <= dec.point_next;
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[Aw-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (consume && dec.count != 2'd0) begin
      queue[wr_ptr] <= dec.res0;
    end
    if (consume && dec.count == 2'd2) begin
      queue[wr_ptr + 1'b1] <= dec.res1;
    end
  end

  // master side
  assign head          = queue[rd_ptr];
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = head.code_unit;
  assign m_axis_tuser  = {head.run_last, head.unit_valid};
  assign m_axis_tlast  = head.string_end;

endmodule
